/* rtl/fss_pkg.sv */
// Package for the fuzzy subsequence scorer: payload widths, register indexes,
// scoring constants, the result word and the character helper functions.
// No dependencies; every other file of the block but fss_text_if imports it.
package fss_pkg;

  localparam int NEEDLE_MAX_DEF   = 8;
  localparam int HAYSTACK_MAX_DEF = 65536;

  localparam int CHARS_W = 64;
  localparam int LEN_W   = 4;
  localparam int POS_W   = 16;
  localparam int SCORE_W = 9;
  localparam int CNT_W   = 4;
  localparam int IDXR_W  = 2;

  // Scoring weights.
  localparam int MATCH_BONUS = 4;
  localparam int ADJ_BONUS   = 8;
  localparam int WORD_BONUS  = 8;
  localparam int GAP_CAP     = 8;
  localparam int START_POS   = -2;

  localparam logic [7:0] CHAR_UPPER_A   = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z   = 8'h5A;
  localparam logic [7:0] CASE_OFFSET    = 8'h20;
  localparam logic [7:0] CHAR_SPACE     = 8'h20;
  localparam logic [7:0] CHAR_UNDERLINE = 8'h5F;
  localparam logic [7:0] CHAR_DASH      = 8'h2D;
  localparam logic [7:0] CHAR_DOT       = 8'h2E;
  localparam logic [7:0] CHAR_SLASH     = 8'h2F;
  localparam logic [7:0] CHAR_COLON     = 8'h3A;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  typedef enum logic [IDXR_W-1:0] {
    REG_NEEDLE_CHARS  = 2'd0,
    REG_NEEDLE_LENGTH = 2'd1,
    REG_MAX_POSITIONS = 2'd2
  } reg_idx_t;

  typedef enum logic {
    KIND_POSITION = 1'b0,
    KIND_VERDICT  = 1'b1
  } res_kind_t;

  typedef struct packed {
    logic [CHARS_W-1:0] needle_chars;
    logic [LEN_W-1:0]   needle_length;
    logic [LEN_W-1:0]   max_positions;
  } cfg_t;

  typedef struct packed {
    res_kind_t                  kind;
    logic [POS_W-1:0]           position;
    logic                       matched;
    logic signed [SCORE_W-1:0]  score;
    logic [CNT_W-1:0]           match_total;
    logic                       final_flag;
  } res_t;

  // Up to two result words per processed item, always packed from slot 0.
  typedef struct packed {
    logic n0;
    logic n1;
    res_t w0;
    res_t w1;
  } push_t;

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    return (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) ? c + CASE_OFFSET : c;
  endfunction

  function automatic logic is_separator(input logic [7:0] c);
    return c == CHAR_SPACE || c == CHAR_UNDERLINE || c == CHAR_DASH ||
           c == CHAR_DOT || c == CHAR_SLASH || c == CHAR_COLON;
  endfunction

endpackage

/* rtl/fss_text_if.sv */
// Haystack input channel: valid/ready handshake with one text word.
// Depends on nothing outside itself.
interface fss_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] haystack_byte;
  logic       no_byte;
  logic       end_of_text;

  modport source(output valid, haystack_byte, no_byte, end_of_text, input ready);
  modport sink(input valid, haystack_byte, no_byte, end_of_text, output ready);
endinterface

/* rtl/fss_result_if.sv */
// Result channel: valid/ready handshake with one position or verdict word.
// Depends on fss_pkg for the field widths.
interface fss_result_if import fss_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      result_kind;
  logic [POS_W-1:0]          position;
  logic                      matched;
  logic signed [SCORE_W-1:0] score;
  logic [CNT_W-1:0]          match_total;
  logic                      final_flag;

  modport source(output valid, result_kind, position, matched, score, match_total,
                 final_flag, input ready);
  modport sink(input valid, result_kind, position, matched, score, match_total,
               final_flag, output ready);
endinterface

/* rtl/fss_cfg_if.sv */
// Configuration write channel: valid/ready with register index and write data.
// Depends on fss_pkg for the field widths.
interface fss_cfg_if import fss_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [IDXR_W-1:0]  index;
  logic [CHARS_W-1:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

/* rtl/fuzzy_subsequence_scorer_core.sv */
// Fuzzy subsequence scorer: streams text words against a configured needle.
// Depends on fss_pkg, the three channel interfaces, fss_cfg_regs, fss_match
// and fss_out_queue.
//
// Usage: write the needle characters (index 0), the needle length (index 1)
// and the position report limit (index 2) on cfg while the block is idle;
// cfg.ready is always high. Then send one text word per haystack byte on
// text, with end_of_text on the last word. Each matched needle character,
// up to the limit, yields a position word on result, and the end_of_text
// word yields a verdict word after any position word of the same item;
// final_flag marks the last result word of an item.
// A text word is held in the input register of fss_match, and its result
// words are written into the result queue, which offers them on result.
// Throughput: one text word per cycle while the queue has room. The result
// channel issues one word a cycle, so a word that causes both a position
// report and a verdict needs two result words; a four-word queue absorbs that.
// When result.ready is low the queue fills and text.ready drops once fewer
// than two free slots remain; nothing is lost.
// Reset clears the configuration registers, the stream state and the queue;
// after every verdict the stream state returns to its reset values.
module fuzzy_subsequence_scorer_core import fss_pkg::*; #(
  parameter int NEEDLE_MAX   = NEEDLE_MAX_DEF,
  parameter int HAYSTACK_MAX = HAYSTACK_MAX_DEF
) (
  input  logic          clk,
  input  logic          rst,
  fss_cfg_if.sink       cfg,
  fss_text_if.sink      text,
  fss_result_if.source  result
);

  cfg_t  regs;
  push_t push;
  logic  room;

  fss_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  fss_match #(
    .NEEDLE_MAX   (NEEDLE_MAX),
    .HAYSTACK_MAX (HAYSTACK_MAX)
  ) u_match (
    .clk  (clk),
    .rst  (rst),
    .text (text),
    .regs (regs),
    .room (room),
    .push (push)
  );

  fss_out_queue u_out_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .room   (room),
    .result (result)
  );

endmodule

/* rtl/fss_cfg_regs.sv */
// Configuration register file: needle characters, needle length, position limit.
// Depends on fss_pkg and fss_cfg_if.
module fss_cfg_regs import fss_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  fss_cfg_if.sink    cfg,
  output cfg_t       regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_NEEDLE_CHARS:  regs.needle_chars  <= cfg.data;
        REG_NEEDLE_LENGTH: regs.needle_length <= cfg.data[LEN_W-1:0];
        REG_MAX_POSITIONS: regs.max_positions <= cfg.data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

/* rtl/fss_match.sv */
// Input register, match and scoring logic, and the per-text stream state.
// Depends on fss_pkg, fss_text_if and the cfg_t word from fss_cfg_regs.
module fss_match import fss_pkg::*; #(
  parameter int NEEDLE_MAX   = NEEDLE_MAX_DEF,
  parameter int HAYSTACK_MAX = HAYSTACK_MAX_DEF
) (
  input  logic     clk,
  input  logic     rst,
  fss_text_if.sink text,
  input  cfg_t     regs,
  input  logic     room,
  output push_t    push
);

  localparam int IDX_W  = $clog2(HAYSTACK_MAX);
  localparam int LAST_W = IDX_W + 1;
  // The gap path also has to hold the gap cap, even for a very short haystack.
  localparam int GAP_W  = (IDX_W + 2 > 6) ? IDX_W + 2 : 6;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(HAYSTACK_MAX - 1);
  localparam logic [LEN_W-1:0] LEN_CAP  = LEN_W'(NEEDLE_MAX);

  // Input register.
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_no_byte;
  logic       s1_eot;

  // Stream state.
  logic [CNT_W-1:0]          needle_index;
  logic [CNT_W-1:0]          matches_so_far;
  logic [IDX_W-1:0]          byte_index;
  logic signed [LAST_W-1:0]  last_match_pos;
  logic signed [SCORE_W-1:0] running_score;
  logic [7:0]                previous_byte;

  logic                      fire;
  logic [LEN_W-1:0]          len;
  logic [LEN_W-1:0]          maxp;
  logic [7:0]                needle_char;
  logic                      hit;
  logic signed [GAP_W-1:0]   idx_s;
  logic signed [GAP_W-1:0]   expected;
  logic signed [GAP_W-1:0]   gap;
  logic [3:0]                gap_c;
  logic                      adjacent;
  logic                      word_start;
  logic [4:0]                bonus;
  logic signed [5:0]         delta;
  logic [CNT_W-1:0]          needle_index_next;
  logic [CNT_W-1:0]          matches_so_far_next;
  logic signed [SCORE_W-1:0] running_score_next;
  logic                      ok;
  logic                      pos_v;
  res_t                      pos_word;
  res_t                      verdict_word;

  assign fire       = s1_valid && room;
  assign text.ready = !s1_valid || room;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (text.ready) begin
      s1_valid <= text.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (text.valid && text.ready) begin
      s1_byte    <= text.haystack_byte;
      s1_no_byte <= text.no_byte;
      s1_eot     <= text.end_of_text;
    end
  end

  always_comb begin
    len  = (regs.needle_length > LEN_CAP) ? LEN_CAP : regs.needle_length;
    maxp = (regs.max_positions > LEN_CAP) ? LEN_CAP : regs.max_positions;
    needle_char = regs.needle_chars[{needle_index[2:0], 3'b000} +: 8];
    hit = !s1_no_byte && (needle_index < len) &&
          (fold_case(s1_byte) == fold_case(needle_char));

    idx_s    = $signed(GAP_W'(byte_index));
    expected = GAP_W'(last_match_pos) + GAP_W'(1);
    gap      = idx_s - expected;
    adjacent = (idx_s == expected);
    // The gap can go negative only once the index has saturated.
    if (gap < 0) begin
      gap_c = 4'd0;
    end else if (gap > GAP_W'(GAP_CAP)) begin
      gap_c = 4'(GAP_CAP);
    end else begin
      gap_c = gap[3:0];
    end
    word_start = (byte_index == '0) || is_separator(previous_byte);
    bonus = 5'(MATCH_BONUS) + (adjacent ? 5'(ADJ_BONUS) : 5'd0) +
            (word_start ? 5'(WORD_BONUS) : 5'd0);
    delta = $signed({1'b0, bonus}) - $signed({2'b00, gap_c});

    needle_index_next   = hit ? needle_index + CNT_W'(1) : needle_index;
    matches_so_far_next = hit ? matches_so_far + CNT_W'(1) : matches_so_far;
    running_score_next  = hit ? running_score + {{(SCORE_W-6){delta[5]}}, delta}
                              : running_score;

    ok    = (len == '0) || (needle_index_next >= len);
    pos_v = hit && (matches_so_far < maxp);

    pos_word             = '0;
    pos_word.kind        = KIND_POSITION;
    pos_word.position    = POS_W'(byte_index);
    pos_word.final_flag  = !s1_eot;

    verdict_word             = '0;
    verdict_word.kind        = KIND_VERDICT;
    verdict_word.matched     = ok;
    verdict_word.score       = (ok && len != '0) ? running_score_next : '0;
    verdict_word.match_total = (ok && len != '0) ? matches_so_far_next : '0;
    verdict_word.final_flag  = 1'b1;

    push.n0 = fire && (pos_v || s1_eot);
    push.n1 = fire && pos_v && s1_eot;
    push.w0 = pos_v ? pos_word : verdict_word;
    push.w1 = verdict_word;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      needle_index   <= '0;
      matches_so_far <= '0;
      byte_index     <= '0;
      last_match_pos <= LAST_W'(START_POS);
      running_score  <= '0;
      previous_byte  <= '0;
    end else if (fire) begin
      if (s1_eot) begin
        needle_index   <= '0;
        matches_so_far <= '0;
        byte_index     <= '0;
        last_match_pos <= LAST_W'(START_POS);
        running_score  <= '0;
        previous_byte  <= '0;
      end else begin
        needle_index   <= needle_index_next;
        matches_so_far <= matches_so_far_next;
        running_score  <= running_score_next;
        if (hit) begin
          last_match_pos <= $signed({1'b0, byte_index});
        end
        if (!s1_no_byte) begin
          previous_byte <= s1_byte;
          if (byte_index != IDX_LAST) begin
            byte_index <= byte_index + IDX_W'(1);
          end
        end
      end
    end
  end

  a_index_tracks_count: assert property (@(posedge clk) disable iff (rst)
    needle_index == matches_so_far)
    else $error("needle index and match count diverged");

  a_index_bounded: assert property (@(posedge clk) disable iff (rst)
    needle_index <= LEN_CAP)
    else $error("needle index ran past the needle");

  a_clear_after_verdict: assert property (@(posedge clk) disable iff (rst)
    fire && s1_eot |=> needle_index == '0 && byte_index == '0 &&
                       running_score == '0)
    else $error("stream state not cleared after the verdict");

endmodule

/* rtl/fss_out_queue.sv */
// Four-word result queue that takes up to two words a cycle and issues one.
// Depends on fss_pkg and fss_result_if.
module fss_out_queue import fss_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  push_t         push,
  output logic          room,
  fss_result_if.source  result
);

  res_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic [QCNT_W-1:0] count_next;
  logic              pop;
  res_t              head;

  // Room for a full two-word push keeps the producer independent of result.ready.
  assign room = count <= QCNT_W'(QUEUE_DEPTH - 2);
  assign pop  = result.valid && result.ready;
  assign head = mem[rd_ptr];

  assign result.valid       = count != '0;
  assign result.result_kind = head.kind;
  assign result.position    = head.position;
  assign result.matched     = head.matched;
  assign result.score       = head.score;
  assign result.match_total = head.match_total;
  assign result.final_flag  = head.final_flag;

  assign count_next = count + QCNT_W'(push.n0) + QCNT_W'(push.n1) - QCNT_W'(pop);

  always_ff @(posedge clk) begin
    if (push.n0) begin
      mem[wr_ptr] <= push.w0;
    end
    if (push.n1) begin
      mem[QPTR_W'(wr_ptr + QPTR_W'(1))] <= push.w1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR_W'(push.n0) + QPTR_W'(push.n1);
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      count <= count_next;
    end
  end

  a_push_needs_room: assert property (@(posedge clk) disable iff (rst)
    push.n0 |-> room)
    else $error("result pushed into a queue without room");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QUEUE_DEPTH))
    else $error("result queue overflow");

endmodule

/* tb/tb_fuzzy_subsequence_scorer_core.sv */
`timescale 1ns / 1ps
// Self-checking testbench for fuzzy_subsequence_scorer_core: drives text words, predicts
// position reports and verdicts with its own scorer model, and compares every result word.
// Depends on fss_pkg, the three channel interfaces and the core itself.
module tb_fuzzy_subsequence_scorer_core;
  import fss_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 6;
  localparam int PHASE_WORDS    = 56;

  typedef struct {
    logic [7:0] haystack_byte;
    logic       no_byte;
    logic       end_of_text;
  } text_word_t;

  logic clk;
  logic rst;

  fss_cfg_if    cfg_bus();
  fss_text_if   text_bus();
  fss_result_if res_bus();

  fuzzy_subsequence_scorer_core u_dut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_bus),
    .text   (text_bus),
    .result (res_bus)
  );

  // Register copies and stream state of the scorer as this bench sees it.
  logic [63:0] needle_reg;
  logic [3:0]  needle_len_reg;
  logic [3:0]  max_pos_reg;
  logic [3:0]  needle_pos;
  int          byte_pos;
  int          last_pos;
  int          score_acc;
  logic [3:0]  match_cnt;
  logic [7:0]  prev_byte;

  text_word_t text_backlog[$];
  res_t       reports_due[$];
  text_word_t next_word;
  res_t       due_word;

  int send_idle_pct;
  int recv_stall_pct;
  int words_sent;
  int words_taken;
  int texts_closed;
  int positions_seen;
  int verdicts_seen;
  int regs_written;
  int mismatches;
  int quiet_cycles;

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [7:0] lower_ascii(input logic [7:0] c);
    if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
      return c + CASE_OFFSET;
    end
    return c;
  endfunction

  function automatic logic breaks_word(input logic [7:0] c);
    return (c == CHAR_SPACE) || (c == CHAR_UNDERLINE) || (c == CHAR_DASH) ||
           (c == CHAR_DOT) || (c == CHAR_SLASH) || (c == CHAR_COLON);
  endfunction

  function automatic logic [7:0] pick_separator();
    case ($urandom_range(5))
      0: return CHAR_SPACE;
      1: return CHAR_UNDERLINE;
      2: return CHAR_DASH;
      3: return CHAR_DOT;
      4: return CHAR_SLASH;
      default: return CHAR_COLON;
    endcase
  endfunction

  function automatic logic [7:0] random_char();
    case ($urandom_range(4))
      0: return 8'h61 + 8'($urandom_range(25));
      1: return CHAR_UPPER_A + 8'($urandom_range(25));
      2: return pick_separator();
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [7:0] maybe_swap_case(input logic [7:0] c);
    logic [7:0] low;
    low = lower_ascii(c);
    if (low >= 8'h61 && low <= 8'h7A && $urandom_range(1) == 1) begin
      return c ^ CASE_OFFSET;
    end
    return c;
  endfunction

  // Small register values are written with random upper bits, which the block must drop.
  function automatic logic [63:0] noisy_nibble(input int v);
    logic [63:0] word;
    word = {$urandom, $urandom};
    word[3:0] = v[3:0];
    return word;
  endfunction

  task automatic reset_stream_state();
    needle_pos = '0;
    byte_pos   = 0;
    last_pos   = START_POS;
    score_acc  = 0;
    match_cnt  = '0;
    prev_byte  = '0;
  endtask

  // Scores one accepted text word and queues the result words it must produce.
  task automatic advance_scorer(input logic [7:0] hb, input logic nb, input logic eot);
    int   len;
    int   limit;
    int   gap;
    res_t w;
    res_t burst[$];
    len   = (needle_len_reg > NEEDLE_MAX_DEF) ? NEEDLE_MAX_DEF : needle_len_reg;
    limit = (max_pos_reg > NEEDLE_MAX_DEF) ? NEEDLE_MAX_DEF : max_pos_reg;
    if (!nb) begin
      if (needle_pos < len &&
          lower_ascii(hb) == lower_ascii(needle_reg[8*needle_pos +: 8])) begin
        gap = byte_pos - (last_pos + 1);
        score_acc += MATCH_BONUS;
        if (byte_pos == last_pos + 1) begin
          score_acc += ADJ_BONUS;
        end
        if (byte_pos == 0 || breaks_word(prev_byte)) begin
          score_acc += WORD_BONUS;
        end
        // A saturated index can repeat, which would give a negative gap.
        if (gap < 0) begin
          gap = 0;
        end
        if (gap > GAP_CAP) begin
          gap = GAP_CAP;
        end
        score_acc -= gap;
        last_pos = byte_pos;
        if (match_cnt < limit) begin
          w = '0;
          w.kind = KIND_POSITION;
          w.position = byte_pos[15:0];
          burst.push_back(w);
        end
        match_cnt++;
        needle_pos++;
      end
      prev_byte = hb;
      if (byte_pos < HAYSTACK_MAX_DEF - 1) begin
        byte_pos++;
      end
    end
    if (eot) begin
      w = '0;
      w.kind = KIND_VERDICT;
      w.matched = (len == 0) || (needle_pos >= len);
      if (w.matched && len != 0) begin
        w.score = SCORE_W'(score_acc);
        w.match_total = match_cnt;
      end
      burst.push_back(w);
      reset_stream_state();
    end
    if (burst.size() != 0) begin
      burst[burst.size()-1].final_flag = 1'b1;
    end
    foreach (burst[i]) begin
      reports_due.push_back(burst[i]);
    end
  endtask

  task automatic compare_field(input string name, input logic signed [31:0] want,
                               input logic signed [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  task automatic push_word(input logic [7:0] hb, input logic nb, input logic eot);
    text_word_t w;
    w.haystack_byte = hb;
    w.no_byte = nb;
    w.end_of_text = eot;
    text_backlog.push_back(w);
    words_sent++;
    if (eot) begin
      texts_closed++;
    end
  endtask

  task automatic program_register(input reg_idx_t idx, input logic [63:0] value);
    @(posedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    @(posedge clk);
    while (!cfg_bus.ready) begin
      @(posedge clk);
    end
    case (idx)
      REG_NEEDLE_CHARS:  needle_reg = value;
      REG_NEEDLE_LENGTH: needle_len_reg = value[3:0];
      REG_MAX_POSITIONS: max_pos_reg = value[3:0];
      default: ;
    endcase
    cfg_bus.valid <= 1'b0;
    regs_written++;
  endtask

  task automatic apply_needle(input logic [63:0] chars, input int len, input int maxp);
    program_register(REG_NEEDLE_CHARS, chars);
    program_register(REG_NEEDLE_LENGTH, noisy_nibble(len));
    program_register(REG_MAX_POSITIONS, noisy_nibble(maxp));
    @(negedge clk);
  endtask

  // Waits until every word is taken and answered, then lets the pipeline settle.
  task automatic drain();
    while (words_taken != words_sent || reports_due.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Needle characters in order spread through filler; noisy texts are random bytes only.
  task automatic queue_text(input int n_bytes, input logic closed, input logic noisy);
    int         nidx;
    logic [7:0] c;
    logic       nb;
    nidx = 0;
    for (int k = 0; k < n_bytes; k++) begin
      nb = ($urandom_range(15) == 0);
      if (!noisy && !nb && nidx < NEEDLE_MAX_DEF && $urandom_range(99) < 50) begin
        c = maybe_swap_case(needle_reg[8*nidx +: 8]);
        nidx++;
      end else if ($urandom_range(3) == 0) begin
        c = pick_separator();
      end else begin
        c = random_char();
      end
      push_word(c, nb, closed && (k == n_bytes - 1));
    end
  endtask

  task automatic fill_phase(input int n_words);
    int start;
    int len;
    start = words_sent;
    len = (needle_len_reg > NEEDLE_MAX_DEF) ? NEEDLE_MAX_DEF : needle_len_reg;
    while (words_sent - start < n_words) begin
      queue_text($urandom_range(1, len + 10), 1'b1, $urandom_range(4) == 0);
    end
    // Leaving a text open lets the next register write land mid-text.
    if ($urandom_range(3) == 0) begin
      queue_text($urandom_range(1, 3), 1'b0, 1'b0);
    end
  endtask

  task automatic program_phase(input int mode, input int ph);
    logic [63:0] chars;
    for (int b = 0; b < NEEDLE_MAX_DEF; b++) begin
      chars[8*b +: 8] = random_char();
    end
    case (ph)
      0: apply_needle((mode == 1) ? '0 : '1, NEEDLE_MAX_DEF, NEEDLE_MAX_DEF);
      1: apply_needle(chars, 15, 15);
      2: apply_needle(chars, 0, 0);
      default: apply_needle(chars,
                            ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(1, 8),
                            $urandom_range(15));
    endcase
  endtask

  // Text driver: offers the backlog word by word and scores each word as it is taken.
  always @(posedge clk) begin
    if (rst) begin
      text_bus.valid <= 1'b0;
    end else begin
      if (text_bus.valid && text_bus.ready) begin
        advance_scorer(text_bus.haystack_byte, text_bus.no_byte, text_bus.end_of_text);
        words_taken++;
      end
      if (!text_bus.valid || text_bus.ready) begin
        if (text_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_word = text_backlog.pop_front();
          text_bus.haystack_byte <= next_word.haystack_byte;
          text_bus.no_byte       <= next_word.no_byte;
          text_bus.end_of_text   <= next_word.end_of_text;
          text_bus.valid         <= 1'b1;
        end else begin
          text_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks each taken word against the oldest prediction.
  always @(posedge clk) begin
    if (rst) begin
      res_bus.ready <= 1'b0;
    end else begin
      if (res_bus.valid && res_bus.ready) begin
        if (reports_due.size() == 0) begin
          $error("unpredicted result word: kind %0d position %0d score %0d",
                 res_bus.result_kind, res_bus.position, res_bus.score);
          mismatches++;
        end else begin
          due_word = reports_due.pop_front();
          compare_field("result_kind", due_word.kind, res_bus.result_kind);
          compare_field("position", due_word.position, res_bus.position);
          compare_field("matched", due_word.matched, res_bus.matched);
          compare_field("score", due_word.score, res_bus.score);
          compare_field("match_total", due_word.match_total, res_bus.match_total);
          compare_field("final_flag", due_word.final_flag, res_bus.final_flag);
          if (due_word.kind == KIND_VERDICT) begin
            verdicts_seen++;
          end else begin
            positions_seen++;
          end
        end
      end
      res_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (text_bus.valid && text_bus.ready) || (res_bus.valid && res_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("Watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst = 1'b1;
    text_bus.valid = 1'b0;
    text_bus.haystack_byte = '0;
    text_bus.no_byte = 1'b0;
    text_bus.end_of_text = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = REG_NEEDLE_CHARS;
    cfg_bus.data = '0;
    res_bus.ready = 1'b0;
    needle_reg = '0;
    needle_len_reg = '0;
    max_pos_reg = '0;
    reset_stream_state();
    send_idle_pct = 17;
    recv_stall_pct = 52;
    words_sent = 0;
    words_taken = 0;
    texts_closed = 0;
    positions_seen = 0;
    verdicts_seen = 0;
    regs_written = 0;
    mismatches = 0;
    quiet_cycles = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset registers give an empty needle: every text matches with score zero.
    push_word(8'h00, 1'b1, 1'b1);
    push_word(8'h78, 1'b0, 1'b1);
    drain();

    // Needle "Ab", NUL, "z": word starts, gaps, adjacency, an empty item, then
    // bytes after the needle is complete. Oversized limit acts as eight.
    apply_needle(64'h0000_0000_7A00_6241, 4, 15);
    push_word(8'h61, 1'b0, 1'b0);
    push_word(8'h78, 1'b0, 1'b0);
    push_word(CHAR_DASH, 1'b0, 1'b0);
    push_word(8'h42, 1'b0, 1'b0);
    push_word(8'h00, 1'b0, 1'b0);
    push_word(8'h00, 1'b1, 1'b0);
    push_word(8'h5A, 1'b0, 1'b0);
    push_word(8'hFF, 1'b0, 1'b0);
    push_word(8'h80, 1'b0, 1'b1);
    drain();

    // Full-width needle of two letters and six separators, with oversized length and two reports.
    apply_needle(64'h3A2F_2E2D_5F20_5A79, 15, 2);
    push_word(8'h59, 1'b0, 1'b0);
    push_word(8'h7A, 1'b0, 1'b0);
    push_word(CHAR_SPACE, 1'b0, 1'b0);
    push_word(CHAR_UNDERLINE, 1'b0, 1'b0);
    push_word(CHAR_DASH, 1'b0, 1'b0);
    push_word(CHAR_DOT, 1'b0, 1'b0);
    push_word(CHAR_SLASH, 1'b0, 1'b0);
    push_word(CHAR_COLON, 1'b0, 1'b1);
    push_word(8'h79, 1'b0, 1'b0);
    push_word(8'h71, 1'b0, 1'b0);
    push_word(8'h00, 1'b1, 1'b1);
    drain();

    // Shortening the needle mid-text completes it at once.
    push_word(8'h59, 1'b0, 1'b0);
    push_word(8'h5A, 1'b0, 1'b0);
    drain();
    program_register(REG_NEEDLE_LENGTH, noisy_nibble(1));
    @(negedge clk);
    push_word(8'h00, 1'b1, 1'b1);

    for (int mode = 0; mode < 3; mode++) begin
      for (int ph = 0; ph < 6; ph++) begin
        drain();
        case (mode)
          0: begin
            send_idle_pct = 17;
            recv_stall_pct = 52;
          end
          1: begin
            send_idle_pct = 52;
            recv_stall_pct = 17;
          end
          default: begin
            send_idle_pct = 0;
            recv_stall_pct = 0;
          end
        endcase
        program_phase(mode, ph);
        fill_phase(PHASE_WORDS);
      end
    end
    drain();

    $display("Run covered %0d text words in %0d closed texts and %0d register writes,",
             words_taken, texts_closed, regs_written);
    $display("with %0d position reports and %0d verdicts compared field by field.",
             positions_seen, verdicts_seen);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* fuzzy_subsequence_scorer_core.f */
rtl/fss_pkg.sv
rtl/fss_text_if.sv
rtl/fss_result_if.sv
rtl/fss_cfg_if.sv
rtl/fss_cfg_regs.sv
rtl/fss_match.sv
rtl/fss_out_queue.sv
rtl/fuzzy_subsequence_scorer_core.sv
tb/tb_fuzzy_subsequence_scorer_core.sv
